[hw/rtl/heatmap_palette_colorizer_top_macros.svh]
// Assertion macros shared by the colorizer checker
`ifndef HEATMAP_PALETTE_COLORIZER_TOP_MACROS_SVH
`define HEATMAP_PALETTE_COLORIZER_TOP_MACROS_SVH

// same-cycle implication
`define HPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/hpc_pkg.sv]
// Types, constants and palette ROM of the heatmap colorizer
`timescale 1ns / 1ps
`default_nettype none

package hpc_pkg;

	localparam int SAMPLE_W  = 24;
	localparam int CFG_W     = 24;
	localparam int DIFF_W    = SAMPLE_W + 1;
	localparam int GAIN_W    = 24;
	localparam int PROD_W    = DIFF_W + GAIN_W;
	localparam int COLOR_W   = 8;
	localparam int IDX_W     = 5;
	localparam int FRAC_W    = 8;
	localparam int POS_SHIFT = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_FLOOR = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_GAIN  = 1'b1;

	localparam logic [GAIN_W-1:0]  GAIN_RESET   = 24'd6226;
	localparam logic [COLOR_W-1:0] NODATA_GRAY  = 8'd127;
	localparam logic [IDX_W-1:0]   PAL_LAST     = 5'd19;
	localparam logic [IDX_W+FRAC_W-1:0] PAL_LAST_POS = 13'd4864;

	typedef struct packed {
		logic valid;
		logic nodata;
	} ctl_t;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} rgb_t;

	function automatic rgb_t palette_rgb(input logic [IDX_W-1:0] idx);
		rgb_t c;
		unique case (idx)
			5'd0:    c = '{8'h44, 8'h01, 8'h54};
			5'd1:    c = '{8'h48, 8'h15, 8'h67};
			5'd2:    c = '{8'h48, 8'h26, 8'h77};
			5'd3:    c = '{8'h45, 8'h37, 8'h81};
			5'd4:    c = '{8'h40, 8'h47, 8'h88};
			5'd5:    c = '{8'h39, 8'h56, 8'h8C};
			5'd6:    c = '{8'h33, 8'h63, 8'h8D};
			5'd7:    c = '{8'h2D, 8'h70, 8'h8E};
			5'd8:    c = '{8'h28, 8'h7D, 8'h8E};
			5'd9:    c = '{8'h23, 8'h8A, 8'h8D};
			5'd10:   c = '{8'h1F, 8'h96, 8'h8B};
			5'd11:   c = '{8'h20, 8'hA3, 8'h87};
			5'd12:   c = '{8'h29, 8'hAF, 8'h7F};
			5'd13:   c = '{8'h3C, 8'hBB, 8'h75};
			5'd14:   c = '{8'h55, 8'hC6, 8'h67};
			5'd15:   c = '{8'h73, 8'hD0, 8'h55};
			5'd16:   c = '{8'h95, 8'hD8, 8'h40};
			5'd17:   c = '{8'hB8, 8'hDE, 8'h29};
			5'd18:   c = '{8'hDC, 8'hE3, 8'h19};
			5'd19:   c = '{8'hFD, 8'hE7, 8'h25};
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/hpc_if.sv]
// Valid/ready channel interfaces for samples and colors
`timescale 1ns / 1ps
`default_nettype none

interface hpc_sample_if;
	logic                              valid;
	logic                              ready;
	logic signed [hpc_pkg::SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface hpc_color_if;
	logic                        valid;
	logic                        ready;
	logic [hpc_pkg::COLOR_W-1:0] blue;
	logic [hpc_pkg::COLOR_W-1:0] green;
	logic [hpc_pkg::COLOR_W-1:0] red;

	modport source (output valid, output blue, output green, output red, input ready);
	modport sink   (input valid, input blue, input green, input red, output ready);
endinterface

`default_nettype wire

[hw/rtl/hpc_scale.sv]
// Stages 1-2: floor subtract, then gain multiply
`timescale 1ns / 1ps
`default_nettype none

module hpc_scale (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                en,
	input  wire logic                                in_valid,
	input  wire logic signed [hpc_pkg::SAMPLE_W-1:0] sample,
	input  wire logic        [hpc_pkg::CFG_W-1:0]    floor_level,
	input  wire logic        [hpc_pkg::GAIN_W-1:0]   span_gain,
	output hpc_pkg::ctl_t                            ctl_s2,
	output logic signed [hpc_pkg::PROD_W-1:0]        prod_s2
);

	hpc_pkg::ctl_t                           ctl_s1;
	logic signed [hpc_pkg::DIFF_W-1:0]       diff_s1;
	logic signed [hpc_pkg::DIFF_W-1:0]       diff_d;
	logic signed [hpc_pkg::GAIN_W:0]         gain_ext;
	logic signed [hpc_pkg::PROD_W:0]         prod_full;

	assign diff_d = {sample[hpc_pkg::SAMPLE_W-1], sample}
		- {floor_level[hpc_pkg::CFG_W-1], floor_level};
	assign gain_ext  = {1'b0, span_gain};
	assign prod_full = diff_s1 * gain_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s1 <= '{valid: in_valid, nodata: (sample == '0)};
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s1 <= diff_d;
			prod_s2 <= prod_full[hpc_pkg::PROD_W-1:0];
		end
	end

endmodule

`default_nettype wire

[hw/rtl/hpc_lookup.sv]
// Stage 3: position clamp and palette ROM reads
`timescale 1ns / 1ps
`default_nettype none

module hpc_lookup (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire hpc_pkg::ctl_t                ctl_s2,
	input  wire logic signed [hpc_pkg::PROD_W-1:0] prod_s2,
	output hpc_pkg::ctl_t                     ctl_s3,
	output hpc_pkg::rgb_t                     lo_s3,
	output hpc_pkg::rgb_t                     hi_s3,
	output logic [hpc_pkg::FRAC_W-1:0]        frac_s3
);

	localparam int POS_W = hpc_pkg::IDX_W + hpc_pkg::FRAC_W;

	logic [hpc_pkg::IDX_W-1:0]  lo_idx;
	logic [hpc_pkg::IDX_W-1:0]  hi_idx;
	logic [hpc_pkg::FRAC_W-1:0] frac;
	logic [POS_W-1:0]           pos_lo;
	logic                       pos_big;

	assign pos_lo  = prod_s2[hpc_pkg::POS_SHIFT +: POS_W];
	assign pos_big = |prod_s2[hpc_pkg::PROD_W-2:hpc_pkg::POS_SHIFT+POS_W];

	always_comb begin
		priority if (prod_s2[hpc_pkg::PROD_W-1] || (prod_s2 == '0)) begin
			lo_idx = '0;
			hi_idx = '0;
			frac   = '0;
		end else if (pos_big || (pos_lo >= hpc_pkg::PAL_LAST_POS)) begin
			lo_idx = hpc_pkg::PAL_LAST;
			hi_idx = hpc_pkg::PAL_LAST;
			frac   = '0;
		end else begin
			lo_idx = pos_lo[POS_W-1:hpc_pkg::FRAC_W];
			hi_idx = pos_lo[POS_W-1:hpc_pkg::FRAC_W] + 1'b1;
			frac   = pos_lo[hpc_pkg::FRAC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s3   <= hpc_pkg::palette_rgb(lo_idx);
			hi_s3   <= hpc_pkg::palette_rgb(hi_idx);
			frac_s3 <= frac;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/hpc_blend.sv]
// Stage 4: per-channel linear blend and output register
`timescale 1ns / 1ps
`default_nettype none

module hpc_blend (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire hpc_pkg::ctl_t         ctl_s3,
	input  wire hpc_pkg::rgb_t         lo_s3,
	input  wire hpc_pkg::rgb_t         hi_s3,
	input  wire logic [hpc_pkg::FRAC_W-1:0] frac_s3,
	output logic                       valid_s4,
	output hpc_pkg::rgb_t              rgb_s4
);

	localparam int WT_W  = hpc_pkg::FRAC_W + 1;
	localparam int ACC_W = hpc_pkg::COLOR_W + WT_W;

	logic [WT_W-1:0] wt_lo;
	logic [WT_W-1:0] wt_hi;
	hpc_pkg::rgb_t   mix;

	function automatic logic [hpc_pkg::COLOR_W-1:0] blend(
		input logic [hpc_pkg::COLOR_W-1:0] lo,
		input logic [hpc_pkg::COLOR_W-1:0] hi,
		input logic [WT_W-1:0]             w_lo,
		input logic [WT_W-1:0]             w_hi
	);
		logic [ACC_W-1:0] acc;
		acc = ACC_W'(lo) * ACC_W'(w_lo) + ACC_W'(hi) * ACC_W'(w_hi);
		return acc[hpc_pkg::FRAC_W +: hpc_pkg::COLOR_W];
	endfunction

	assign wt_hi = {1'b0, frac_s3};
	assign wt_lo = (WT_W'(1) << hpc_pkg::FRAC_W) - wt_hi;

	always_comb begin
		if (ctl_s3.nodata) begin
			mix = '{hpc_pkg::NODATA_GRAY, hpc_pkg::NODATA_GRAY, hpc_pkg::NODATA_GRAY};
		end else begin
			mix.red   = blend(lo_s3.red,   hi_s3.red,   wt_lo, wt_hi);
			mix.green = blend(lo_s3.green, hi_s3.green, wt_lo, wt_hi);
			mix.blue  = blend(lo_s3.blue,  hi_s3.blue,  wt_lo, wt_hi);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= ctl_s3.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rgb_s4 <= mix;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/heatmap_palette_colorizer_top.sv]
// Top level of the heatmap palette colorizer
//
//   channel   dir  payload                     handshake
//   samples   in   sample[23:0] signed Q15.8   valid/ready
//   colors    out  blue, green, red [7:0]      valid/ready
//   cfg       in   cfg_index, cfg_data[23:0]   cfg_we, no ready
//
// Four register stages: subtract, multiply, palette read, blend.
// One item per clock unless colors stalls; valid passes s1, s2, s3 to colors.valid.
// All stages advance together when the output register is empty or taken;
// samples.ready drops only while a result waits on colors.
// arst_n clears valid bits; floor_level resets to 0 and span_gain to 6226.
`timescale 1ns / 1ps
`default_nettype none

module heatmap_palette_colorizer_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [hpc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [hpc_pkg::CFG_W-1:0]         cfg_data,
	hpc_sample_if.sink                             samples,
	hpc_color_if.source                            colors
);

	logic [hpc_pkg::CFG_W-1:0]          floor_level_q;
	logic [hpc_pkg::GAIN_W-1:0]         span_gain_q;
	logic                               en;
	hpc_pkg::ctl_t                      ctl_s2;
	hpc_pkg::ctl_t                      ctl_s3;
	logic signed [hpc_pkg::PROD_W-1:0]  prod_s2;
	hpc_pkg::rgb_t                      lo_s3;
	hpc_pkg::rgb_t                      hi_s3;
	logic [hpc_pkg::FRAC_W-1:0]         frac_s3;
	logic                               valid_s4;
	hpc_pkg::rgb_t                      rgb_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_level_q <= '0;
			span_gain_q   <= hpc_pkg::GAIN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hpc_pkg::CFG_IDX_FLOOR: floor_level_q <= cfg_data;
				hpc_pkg::CFG_IDX_GAIN:  span_gain_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en            = !valid_s4 || colors.ready;
	assign samples.ready = en;

	hpc_scale u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (samples.valid),
		.sample      (samples.sample),
		.floor_level (floor_level_q),
		.span_gain   (span_gain_q),
		.ctl_s2      (ctl_s2),
		.prod_s2     (prod_s2)
	);

	hpc_lookup u_lookup (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_s2  (ctl_s2),
		.prod_s2 (prod_s2),
		.ctl_s3  (ctl_s3),
		.lo_s3   (lo_s3),
		.hi_s3   (hi_s3),
		.frac_s3 (frac_s3)
	);

	hpc_blend u_blend (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.ctl_s3   (ctl_s3),
		.lo_s3    (lo_s3),
		.hi_s3    (hi_s3),
		.frac_s3  (frac_s3),
		.valid_s4 (valid_s4),
		.rgb_s4   (rgb_s4)
	);

	assign colors.valid = valid_s4;
	assign colors.blue  = rgb_s4.blue;
	assign colors.green = rgb_s4.green;
	assign colors.red   = rgb_s4.red;

endmodule

`default_nettype wire

[hw/rtl/hpc_checker.sv]
// Port-level assertions for the colorizer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "heatmap_palette_colorizer_top_macros.svh"

module hpc_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                in_valid,
	input wire logic                                in_ready,
	input wire logic signed [hpc_pkg::SAMPLE_W-1:0] in_sample,
	input wire logic                                out_valid,
	input wire logic                                out_ready,
	input wire logic [hpc_pkg::COLOR_W-1:0]         out_blue,
	input wire logic [hpc_pkg::COLOR_W-1:0]         out_green,
	input wire logic [hpc_pkg::COLOR_W-1:0]         out_red
);

	`HPC_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "colors.valid dropped while stalled")

	`HPC_ASSERT_IMP(a_ready_stall, clk, arst_n, !in_ready, out_valid && !out_ready, "samples.ready low without output stall")

	`HPC_ASSERT_NXT(a_nodata_gray, clk, arst_n, (in_valid && in_ready && (in_sample == '0)) ##1 out_ready ##1 out_ready ##1 out_ready, out_valid && (out_blue == hpc_pkg::NODATA_GRAY) && (out_green == hpc_pkg::NODATA_GRAY) && (out_red == hpc_pkg::NODATA_GRAY), "zero sample did not give gray after four cycles")

endmodule

bind heatmap_palette_colorizer_top hpc_checker u_hpc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.in_sample (samples.sample),
	.out_valid (colors.valid),
	.out_ready (colors.ready),
	.out_blue  (colors.blue),
	.out_green (colors.green),
	.out_red   (colors.red)
);

`default_nettype wire

[verif/hpc_color_checker.sv]
// Colorizer checker: predicts the color of each accepted sample and compares results
`timescale 1ns / 1ps

module hpc_color_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [hpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hpc_pkg::CFG_W-1:0]     cfg_data,
	hpc_sample_if                         samples,
	hpc_color_if                          colors,
	output int                            mismatches,
	output int                            outstanding
);
	import hpc_pkg::*;

	localparam logic [7:0]  GRAY_LEVEL = 8'd127;
	localparam longint      TOP_POS    = 4864;
	localparam int unsigned TOP_ENTRY  = 19;
	localparam int          REPORT_MAX = 10;

	// RRGGBB
	localparam logic [23:0] VIRIDIS [20] = '{
		24'h440154, 24'h481567, 24'h482677, 24'h453781, 24'h404788,
		24'h39568C, 24'h33638D, 24'h2D708E, 24'h287D8E, 24'h238A8D,
		24'h1F968B, 24'h20A387, 24'h29AF7F, 24'h3CBB75, 24'h55C667,
		24'h73D055, 24'h95D840, 24'hB8DE29, 24'hDCE319, 24'hFDE725
	};

	logic signed [CFG_W-1:0] floor_q = '0;
	logic [GAIN_W-1:0]       gain_q  = GAIN_RESET;
	rgb_t                    expected_colors [$];

	initial begin
		mismatches  = 0;
		outstanding = 0;
	end

	function automatic logic [7:0] mix(input logic [7:0] lo, input logic [7:0] hi,
			input int unsigned f);
		int unsigned acc;
		acc = lo * (256 - f) + hi * f;
		return acc[15:8];
	endfunction

	function automatic rgb_t colorize(input logic signed [23:0] s,
			input logic signed [23:0] flr, input logic [23:0] gain);
		longint      prod;
		longint      pos;
		int unsigned lo;
		int unsigned hi;
		int unsigned f;
		logic [23:0] a;
		logic [23:0] b;
		rgb_t        c;
		if (s == 0) begin
			c.red   = GRAY_LEVEL;
			c.green = GRAY_LEVEL;
			c.blue  = GRAY_LEVEL;
			return c;
		end
		prod = (longint'(s) - longint'(flr)) * longint'(gain);
		if (prod <= 0) begin
			lo = 0;
			hi = 0;
			f  = 0;
		end else begin
			pos = prod >>> 16;
			if (pos >= TOP_POS) begin
				lo = TOP_ENTRY;
				hi = TOP_ENTRY;
				f  = 0;
			end else begin
				lo = int'(pos >>> 8);
				hi = lo + 1;
				f  = int'(pos & 255);
			end
		end
		a = VIRIDIS[lo];
		b = VIRIDIS[hi];
		c.red   = mix(a[23:16], b[23:16], f);
		c.green = mix(a[15:8], b[15:8], f);
		c.blue  = mix(a[7:0], b[7:0], f);
		return c;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rgb_t want;
		if (!arst_n) begin
			floor_q = '0;
			gain_q  = GAIN_RESET;
			expected_colors.delete();
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_IDX_FLOOR)
					floor_q = cfg_data;
				else if (cfg_index == CFG_IDX_GAIN)
					gain_q = cfg_data;
			end
			if (colors.valid && colors.ready) begin
				if (expected_colors.size() == 0) begin
					if (mismatches < REPORT_MAX)
						$display("unexpected color r=%0d g=%0d b=%0d",
							colors.red, colors.green, colors.blue);
					mismatches++;
				end else begin
					want = expected_colors.pop_front();
					if (colors.red !== want.red || colors.green !== want.green ||
							colors.blue !== want.blue) begin
						if (mismatches < REPORT_MAX)
							$display("color mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
								want.red, want.green, want.blue,
								colors.red, colors.green, colors.blue);
						mismatches++;
					end
				end
			end
			if (samples.valid && samples.ready)
				expected_colors.push_back(colorize(samples.sample, floor_q, gain_q));
			outstanding = expected_colors.size();
		end
	end

endmodule

[verif/tb_heatmap_palette_colorizer_top.sv]
// Testbench top: drives samples, colors backpressure and registers, gives the verdict
`timescale 1ns / 1ps

module tb_heatmap_palette_colorizer_top;
	import hpc_pkg::*;

	localparam int     SETTLE_CYCLES = 8;
	localparam int     STALL_LIMIT   = 1000;
	localparam int     PHASES        = 10;
	localparam int     PHASE_ITEMS   = 175;
	localparam longint SPAN_SCALE    = 318767104;
	localparam longint SAMPLE_MIN    = -8388608;
	localparam longint SAMPLE_MAX    = 8388607;

	localparam logic [23:0] RESET_SET [13] = '{
		24'd0, 24'd1, 24'hFFFFFF, 24'h7FFFFF, 24'h800000, 24'd51199, 24'd51200,
		24'd256, 24'd25600, 24'd2560, 24'd12800, 24'd40000, 24'hFFFF00
	};
	localparam logic [23:0] STEEP_SET [4] = '{
		24'h800000, 24'h800001, 24'h800013, 24'h800014
	};

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_IDX_FLOOR;
	logic [CFG_W-1:0]     cfg_data  = '0;
	bit                   steady    = 1'b0;
	int                   mismatches;
	int                   outstanding;
	int                   idle_cycles = 0;

	hpc_sample_if smp ();
	hpc_color_if  col ();

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	heatmap_palette_colorizer_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.samples   (smp),
		.colors    (col)
	);

	hpc_color_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.samples     (smp),
		.colors      (col),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		smp.valid  = 1'b0;
		smp.sample = '0;
		col.ready  = 1'b0;
	end

	always @(posedge clk) begin
		if ((smp.valid && smp.ready) || (col.valid && col.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// colors backpressure
	initial begin
		int stall;
		wait (arst_n);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 3);
			repeat (stall) begin
				@(negedge clk) col.ready <= 1'b0;
				@(posedge clk);
			end
			@(negedge clk) col.ready <= 1'b1;
			do @(posedge clk); while (!col.valid);
		end
	end

	task automatic push_sample(input logic [23:0] v);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 3);
		repeat (gap) begin
			@(negedge clk) smp.valid <= 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		smp.valid  <= 1'b1;
		smp.sample <= v;
		do @(posedge clk); while (!smp.ready);
	endtask

	task automatic settle();
		@(negedge clk) smp.valid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk) cfg_we <= 1'b0;
	endtask

	task automatic set_regs(input logic [23:0] flr, input logic [23:0] gain);
		write_reg(CFG_IDX_FLOOR, flr);
		write_reg(CFG_IDX_GAIN, gain);
	endtask

	// mostly around the mapped range, some zero, some anywhere
	function automatic logic [23:0] pick_sample(input longint flr, input longint span);
		int unsigned sel;
		longint      v;
		sel = $urandom_range(0, 99);
		if (sel < 5)
			return 24'd0;
		if (sel < 20)
			return 24'($urandom);
		if (sel < 28)
			v = flr + longint'($urandom_range(0, 16)) - 8;
		else if (sel < 36)
			v = flr + span + longint'($urandom_range(0, 16)) - 8;
		else
			v = flr - span / 16 + longint'($urandom_range(0, 32'(span + span / 8)));
		if (v < SAMPLE_MIN)
			v = SAMPLE_MIN;
		if (v > SAMPLE_MAX)
			v = SAMPLE_MAX;
		return v[23:0];
	endfunction

	initial begin
		logic signed [23:0] flr;
		logic [23:0]        gain;
		longint             span;
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// registers at reset values
		foreach (RESET_SET[i])
			push_sample(RESET_SET[i]);

		// lowest floor, highest gain
		settle();
		set_regs(24'h800000, 24'hFFFFFF);
		foreach (STEEP_SET[i])
			push_sample(STEEP_SET[i]);

		// zero gain: all nonzero samples land on the first entry
		settle();
		set_regs(24'h7FFFFF, 24'd0);
		push_sample(24'd5);
		push_sample(24'hFFFFFB);

		for (int p = 0; p < PHASES; p++) begin
			settle();
			case (p)
				0: begin
					flr  = 24'd0;
					gain = GAIN_RESET;
					span = 51200;
				end
				1: begin
					flr  = 24'h800000;
					gain = 24'hFFFFFF;
					span = 19;
				end
				2: begin
					flr  = 24'h7FFFFF;
					gain = 24'd0;
					span = 4096;
				end
				3: begin
					flr  = 24'h800000;
					gain = 24'd19;
					span = 16777215;
				end
				4: begin
					flr  = 24'($urandom);
					gain = 24'($urandom);
					span = (gain == 0) ? 4096 : SPAN_SCALE / longint'(gain);
					if (span == 0)
						span = 1;
				end
				default: begin
					flr  = 24'($urandom);
					span = longint'($urandom_range(20, 1 << 20));
					gain = 24'(SPAN_SCALE / span);
				end
			endcase
			set_regs(flr, gain);
			steady = (p % 3 == 2);
			repeat (PHASE_ITEMS)
				push_sample(pick_sample(longint'(flr), span));
			steady = 1'b0;
		end

		settle();
		if (mismatches == 0 && outstanding == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/hpc_pkg.sv
hw/rtl/hpc_if.sv
hw/rtl/hpc_scale.sv
hw/rtl/hpc_lookup.sv
hw/rtl/hpc_blend.sv
hw/rtl/heatmap_palette_colorizer_top.sv
hw/rtl/hpc_checker.sv
verif/hpc_color_checker.sv
verif/tb_heatmap_palette_colorizer_top.sv
